@@ rtl/core/priority_load_unload_scheduler_top_macros.svh @@
// Assertion macros used by the scheduler top level
`ifndef PRIORITY_LOAD_UNLOAD_SCHEDULER_TOP_MACROS_SVH
`define PRIORITY_LOAD_UNLOAD_SCHEDULER_TOP_MACROS_SVH

// Concurrent property checked on every clock out of reset
`define PLUS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Plain invariant checked on every clock out of reset
`define PLUS_INVARIANT(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) else $error(msg);

`endif

@@ rtl/core/plus_pkg.sv @@
// Types, constants and codes of the load/unload scheduler
package plus_pkg;

    localparam int TABLE_DEPTH   = 64;
    localparam int COORD_BITS    = 16;
    localparam int PRIORITY_BITS = 15;
    localparam int KEY_W         = 2 * COORD_BITS;
    localparam int IDX_W         = $clog2(TABLE_DEPTH);
    localparam int CNT_W         = $clog2(TABLE_DEPTH + 1);
    localparam int HANDLE_W      = 16;
    localparam int UPRIO_W       = 17;

    localparam logic [2:0] FN_LOAD     = 3'd0;
    localparam logic [2:0] FN_UNLOAD   = 3'd1;
    localparam logic [2:0] FN_CANCEL   = 3'd2;
    localparam logic [2:0] FN_SWAP     = 3'd3;
    localparam logic [2:0] FN_DISPATCH = 3'd4;

    localparam logic [2:0] ST_QUEUED     = 3'd0;
    localparam logic [2:0] ST_RESOLVED   = 3'd1;
    localparam logic [2:0] ST_DISPATCHED = 3'd2;
    localparam logic [2:0] ST_IDLE       = 3'd3;
    localparam logic [2:0] ST_DUPLICATE  = 3'd4;
    localparam logic [2:0] ST_FULL       = 3'd5;
    localparam logic [2:0] ST_NOT_FOUND  = 3'd6;
    localparam logic [2:0] ST_NOT_PAUSED = 3'd7;

    localparam logic [1:0] REG_DEFAULT_UPRIO = 2'd0;
    localparam logic [1:0] REG_THRESHOLD     = 2'd1;
    localparam logic [1:0] REG_LOADS_PER_UNL = 2'd2;
    localparam logic [1:0] REG_PAUSED        = 2'd3;

    localparam logic [1:0] WOP_CLEAR  = 2'd0;
    localparam logic [1:0] WOP_INSERT = 2'd1;
    localparam logic [1:0] WOP_PRIO   = 2'd2;

    typedef struct packed {
        logic [2:0]                 func;
        logic [COORD_BITS-1:0]      chunk_x;
        logic [COORD_BITS-1:0]      chunk_y;
        logic [PRIORITY_BITS-1:0]   priority_req;
        logic [HANDLE_W-1:0]        buffer_handle;
    } t_in_item;

    typedef struct packed {
        logic [2:0]                 status;
        logic                       kind;
        logic [COORD_BITS-1:0]      out_x;
        logic [COORD_BITS-1:0]      out_y;
        logic [HANDLE_W-1:0]        out_handle;
        logic [PRIORITY_BITS-1:0]   old_priority;
    } t_out_item;

    // probe record handed from cell to cell
    typedef struct packed {
        logic                       active;
        logic [KEY_W-1:0]           key;
        logic                       hit;
        logic [IDX_W-1:0]           hit_idx;
        logic                       hit_unl;
        logic [PRIORITY_BITS-1:0]   hit_prio;
        logic [HANDLE_W-1:0]        hit_handle;
        logic                       free;
        logic [IDX_W-1:0]           free_idx;
        logic                       ld;
        logic [IDX_W-1:0]           ld_idx;
        logic [PRIORITY_BITS-1:0]   ld_prio;
        logic [KEY_W-1:0]           ld_key;
        logic                       ul;
        logic [IDX_W-1:0]           ul_idx;
        logic [KEY_W-1:0]           ul_key;
        logic [HANDLE_W-1:0]        ul_handle;
    } t_scan;

    // write command broadcast to all cells
    typedef struct packed {
        logic                       en;
        logic [1:0]                 op;
        logic [IDX_W-1:0]           idx;
        logic                       is_unload;
        logic [KEY_W-1:0]           key;
        logic [PRIORITY_BITS-1:0]   prio;
        logic [HANDLE_W-1:0]        handle;
    } t_wr;

endpackage

@@ rtl/core/plus_cell.sv @@
// One table slot: compares against the passing probe and takes write commands
module plus_cell (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic [plus_pkg::IDX_W-1:0]          i_index,
    input  plus_pkg::t_scan                     i_scan,
    input  plus_pkg::t_wr                       i_wr,
    output plus_pkg::t_scan                     o_scan
);

    logic                               r_valid;
    logic                               r_unl;
    logic [plus_pkg::KEY_W-1:0]         r_key;
    logic [plus_pkg::PRIORITY_BITS-1:0] r_prio;
    logic [plus_pkg::HANDLE_W-1:0]      r_handle;
    plus_pkg::t_scan                    r_scan;
    plus_pkg::t_scan                    n_scan;
    logic                               sel;

    assign sel = i_wr.en && (i_wr.idx == i_index);

    always_comb begin
        n_scan = i_scan;
        if (i_scan.active) begin
            if (r_valid && (r_key == i_scan.key) && !i_scan.hit) begin
                n_scan.hit        = 1'b1;
                n_scan.hit_idx    = i_index;
                n_scan.hit_unl    = r_unl;
                n_scan.hit_prio   = r_prio;
                n_scan.hit_handle = r_handle;
            end
            if (!r_valid && !i_scan.free) begin
                n_scan.free     = 1'b1;
                n_scan.free_idx = i_index;
            end
            if (r_valid && r_unl && !i_scan.ul) begin
                n_scan.ul        = 1'b1;
                n_scan.ul_idx    = i_index;
                n_scan.ul_key    = r_key;
                n_scan.ul_handle = r_handle;
            end
            // strict compare keeps the lowest slot among equal priorities
            if (r_valid && !r_unl && (!i_scan.ld || (r_prio < i_scan.ld_prio))) begin
                n_scan.ld      = 1'b1;
                n_scan.ld_idx  = i_index;
                n_scan.ld_prio = r_prio;
                n_scan.ld_key  = r_key;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_scan  <= '0;
        end else begin
            r_scan <= n_scan;
            if (sel && (i_wr.op == plus_pkg::WOP_CLEAR)) begin
                r_valid <= 1'b0;
            end else if (sel && (i_wr.op == plus_pkg::WOP_INSERT)) begin
                r_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (sel && (i_wr.op == plus_pkg::WOP_INSERT)) begin
            r_unl    <= i_wr.is_unload;
            r_key    <= i_wr.key;
            r_prio   <= i_wr.prio;
            r_handle <= i_wr.handle;
        end else if (sel && (i_wr.op == plus_pkg::WOP_PRIO)) begin
            r_prio <= i_wr.prio;
        end
    end

    assign o_scan = r_scan;

endmodule

@@ rtl/core/priority_load_unload_scheduler_top.sv @@
// Top level of the load/unload scheduler: control, registers and the row of slot cells
//
//  channel | direction | handshake          | payload
//  in      | input     | i_in_valid/o_in_stall   | t_in_item
//  out     | output    | o_out_valid/i_out_stall | t_out_item
//  config  | input     | APB psel/penable/pwrite | 32-bit registers
//
// Each item is registered on acceptance and its probe walks the row of cells
// one slot a cycle; r_res then latches the probe and the S_DONE state writes back and issues the result.
// Reset clears all slot valid bits at once; no clearing pass is needed.
// A waiting result does not block the next item; a finished item waits only if
// the previous result is still held by i_out_stall.
`include "priority_load_unload_scheduler_top_macros.svh"

module priority_load_unload_scheduler_top (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  plus_pkg::t_in_item   i_in,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output plus_pkg::t_out_item  o_out,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [3:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    localparam logic [1:0] REG_SEL_DEFAULT = plus_pkg::REG_DEFAULT_UPRIO;
    localparam logic [1:0] REG_SEL_THR     = plus_pkg::REG_THRESHOLD;
    localparam logic [1:0] REG_SEL_LPU     = plus_pkg::REG_LOADS_PER_UNL;
    localparam logic [1:0] REG_SEL_PAUSED  = plus_pkg::REG_PAUSED;

    logic [1:0]                          r_state;
    logic                                r_inject;
    plus_pkg::t_in_item                  r_item;
    plus_pkg::t_scan                     r_res;
    plus_pkg::t_out_item                 r_out;
    logic                                r_out_valid;
    logic [plus_pkg::CNT_W-1:0]          r_uc;
    logic [plus_pkg::CNT_W-1:0]          n_uc;
    logic [plus_pkg::UPRIO_W-1:0]        r_up;
    logic [plus_pkg::UPRIO_W-1:0]        n_up;
    logic [14:0]                         r_def;
    logic [6:0]                          r_thr;
    logic [7:0]                          r_lpu;
    logic                                r_paused;
    plus_pkg::t_scan                     chain [0:plus_pkg::TABLE_DEPTH];
    plus_pkg::t_wr                       wr;
    plus_pkg::t_out_item                 n_out;
    logic                                finish;
    logic                                take;
    logic [plus_pkg::KEY_W-1:0]          key;
    logic [plus_pkg::CNT_W-1:0]          uc_after;
    logic signed [plus_pkg::UPRIO_W:0]   up_ext;
    logic signed [plus_pkg::UPRIO_W:0]   up_dec;
    logic signed [plus_pkg::UPRIO_W:0]   up_inc;
    logic                                cfg_wr;

    assign pready     = 1'b1;
    assign o_in_stall = (r_state != S_IDLE);
    assign cfg_wr     = psel && penable && pwrite && pready;
    assign finish     = (r_state == S_DONE) && (!r_out_valid || !i_out_stall);
    assign key        = {r_item.chunk_x, r_item.chunk_y};

    always_comb begin
        chain[0]        = '0;
        chain[0].active = r_inject;
        chain[0].key    = key;
    end

    for (genvar g = 0; g < plus_pkg::TABLE_DEPTH; g++) begin : g_cell
        plus_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_index (plus_pkg::IDX_W'(g)),
            .i_scan  (chain[g]),
            .i_wr    (wr),
            .o_scan  (chain[g+1])
        );
    end

    assign up_ext = $signed({r_up[plus_pkg::UPRIO_W-1], r_up});
    assign up_dec = up_ext - 18'sd1;
    assign up_inc = up_ext + $signed({10'd0, r_lpu});

    always_comb begin
        n_out         = '0;
        n_out.status  = plus_pkg::ST_IDLE;
        wr            = '0;
        wr.key        = key;
        wr.prio       = r_item.priority_req;
        wr.handle     = r_item.buffer_handle;
        n_uc          = r_uc;
        n_up          = r_up;
        take          = 1'b0;
        uc_after      = r_uc;
        case (r_item.func)
            plus_pkg::FN_LOAD, plus_pkg::FN_UNLOAD: begin
                if ((r_item.func == plus_pkg::FN_UNLOAD) && !r_paused) begin
                    n_out.status = plus_pkg::ST_NOT_PAUSED;
                end else if (r_res.hit) begin
                    if ((r_item.func == plus_pkg::FN_LOAD) && r_res.hit_unl) begin
                        n_out.status     = plus_pkg::ST_RESOLVED;
                        n_out.out_x      = r_item.chunk_x;
                        n_out.out_y      = r_item.chunk_y;
                        n_out.out_handle = r_res.hit_handle;
                        wr.en            = 1'b1;
                        wr.op            = plus_pkg::WOP_CLEAR;
                        wr.idx           = r_res.hit_idx;
                        if (r_uc != '0) n_uc = r_uc - 1'b1;
                    end else begin
                        n_out.status = plus_pkg::ST_DUPLICATE;
                    end
                end else if (!r_res.free) begin
                    n_out.status = plus_pkg::ST_FULL;
                end else begin
                    n_out.status = plus_pkg::ST_QUEUED;
                    wr.en        = 1'b1;
                    wr.op        = plus_pkg::WOP_INSERT;
                    wr.idx       = r_res.free_idx;
                    wr.is_unload = (r_item.func == plus_pkg::FN_UNLOAD);
                    if (r_item.func == plus_pkg::FN_UNLOAD) begin
                        wr.prio = '0;
                        n_uc    = r_uc + 1'b1;
                    end else begin
                        wr.handle = '0;
                    end
                end
            end
            plus_pkg::FN_CANCEL, plus_pkg::FN_SWAP: begin
                if (!r_res.hit || ((r_item.func == plus_pkg::FN_SWAP) && r_res.hit_unl)) begin
                    n_out.status = plus_pkg::ST_NOT_FOUND;
                end else begin
                    n_out.status = plus_pkg::ST_QUEUED;
                    n_out.out_x  = r_item.chunk_x;
                    n_out.out_y  = r_item.chunk_y;
                    wr.en        = 1'b1;
                    wr.idx       = r_res.hit_idx;
                    if (r_item.func == plus_pkg::FN_CANCEL) begin
                        wr.op = plus_pkg::WOP_CLEAR;
                        if (r_res.hit_unl && (r_uc != '0)) n_uc = r_uc - 1'b1;
                    end else begin
                        wr.op              = plus_pkg::WOP_PRIO;
                        n_out.old_priority = r_res.hit_prio;
                    end
                end
            end
            plus_pkg::FN_DISPATCH: begin
                if (!r_paused && (r_res.ld || r_res.ul)) begin
                    if (!r_res.ld) begin
                        take = 1'b1;
                    end else if (r_res.ul) begin
                        take = $signed({3'd0, r_res.ld_prio}) > up_ext;
                    end
                    n_out.status = plus_pkg::ST_DISPATCHED;
                    n_out.kind   = take;
                    wr.en        = 1'b1;
                    wr.op        = plus_pkg::WOP_CLEAR;
                    if (take) begin
                        n_out.out_x      = r_res.ul_key[plus_pkg::KEY_W-1:plus_pkg::COORD_BITS];
                        n_out.out_y      = r_res.ul_key[plus_pkg::COORD_BITS-1:0];
                        n_out.out_handle = r_res.ul_handle;
                        wr.idx           = r_res.ul_idx;
                        if (r_uc != '0) uc_after = r_uc - 1'b1;
                    end else begin
                        n_out.out_x        = r_res.ld_key[plus_pkg::KEY_W-1:plus_pkg::COORD_BITS];
                        n_out.out_y        = r_res.ld_key[plus_pkg::COORD_BITS-1:0];
                        n_out.old_priority = r_res.ld_prio;
                        wr.idx             = r_res.ld_idx;
                    end
                    n_uc = uc_after;
                    // unload priority: default if none left, -thr at threshold, else saturating step
                    if (uc_after == '0) begin
                        n_up = plus_pkg::UPRIO_W'(r_def);
                    end else if (32'(uc_after) >= 32'(r_thr)) begin
                        n_up = plus_pkg::UPRIO_W'(0) - plus_pkg::UPRIO_W'(r_thr);
                    end else if (!take) begin
                        if (up_dec[plus_pkg::UPRIO_W] != up_dec[plus_pkg::UPRIO_W-1]) begin
                            n_up = {1'b1, {(plus_pkg::UPRIO_W-1){1'b0}}};
                        end else begin
                            n_up = up_dec[plus_pkg::UPRIO_W-1:0];
                        end
                    end else begin
                        if (up_inc[plus_pkg::UPRIO_W] != up_inc[plus_pkg::UPRIO_W-1]) begin
                            n_up = {1'b0, {(plus_pkg::UPRIO_W-1){1'b1}}};
                        end else begin
                            n_up = up_inc[plus_pkg::UPRIO_W-1:0];
                        end
                    end
                end
            end
            default: begin
                n_out.status = plus_pkg::ST_IDLE;
            end
        endcase
        if (!finish) wr.en = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_inject    <= 1'b0;
            r_out_valid <= 1'b0;
            r_uc        <= '0;
            r_up        <= '0;
            r_def       <= '0;
            r_thr       <= 7'd16;
            r_lpu       <= 8'd4;
            r_paused    <= 1'b0;
        end else begin
            r_inject <= 1'b0;
            // a new result replaces the one taken at this edge
            if (finish) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_inject <= 1'b1;
                        r_state  <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (chain[plus_pkg::TABLE_DEPTH].active) r_state <= S_DONE;
                end
                S_DONE: begin
                    if (finish) begin
                        r_uc    <= n_uc;
                        r_up    <= n_up;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
            if (cfg_wr) begin
                unique case (paddr[3:2])
                    REG_SEL_DEFAULT: r_def    <= pwdata[14:0];
                    REG_SEL_THR:     r_thr    <= pwdata[6:0];
                    REG_SEL_LPU:     r_lpu    <= pwdata[7:0];
                    REG_SEL_PAUSED:  r_paused <= pwdata[0];
                    default:         r_paused <= r_paused;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_IDLE) && i_in_valid) r_item <= i_in;
        if ((r_state == S_SCAN) && chain[plus_pkg::TABLE_DEPTH].active) begin
            r_res <= chain[plus_pkg::TABLE_DEPTH];
        end
        if (finish) r_out <= n_out;
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_SEL_DEFAULT: prdata = {17'd0, r_def};
            REG_SEL_THR:     prdata = {25'd0, r_thr};
            REG_SEL_LPU:     prdata = {24'd0, r_lpu};
            REG_SEL_PAUSED:  prdata = {31'd0, r_paused};
            default:         prdata = '0;
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    `PLUS_ASSERT(a_accept_injects, (i_in_valid && !o_in_stall) |=> r_inject, "probe not launched")
    `PLUS_ASSERT(a_out_held, (r_out_valid && i_out_stall) |=> r_out_valid, "result dropped")
    `PLUS_ASSERT(a_wr_only_done, wr.en |-> (r_state == S_DONE), "table write outside completion")
    `PLUS_INVARIANT(a_uc_bound, 32'(r_uc) <= plus_pkg::TABLE_DEPTH, "unload count overflow")

endmodule
